// ----- hw/rtl/beg_pkg.sv -----
// Shared types, constants and elaboration-time tables for the envelope gain block.
// No dependencies; every module of the block imports it.
package beg_pkg;

    localparam int CFG_TOTAL = 0;
    localparam int CFG_MODE  = 1;
    localparam int CFG_COUNT = 2;

    localparam logic [31:0] TINY_Q30 = 32'd1074;
    localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
    localparam logic [41:0] HALF_Q16 = 42'd32768;

    typedef struct packed {
        logic [16:0] ptime;
        logic [15:0] level;
    } t_point;

    typedef logic [31:0] t_fac_arr [16];

    typedef enum logic [4:0] {
        S_IDLE, S_SEGCHK, S_T0, S_T1, S_LEN, S_L0, S_L1,
        S_LIN_M, S_LIN_D,
        S_LG_NORM, S_LG_SQ, S_LG_SQW,
        S_EX_M, S_EX_MW, S_EX_D, S_EX_STEP, S_EX_W, S_EX_Y, S_EX_G,
        S_FIN, S_ADV, S_SMUL, S_OUT
    } t_state;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        n = v;
        res = 64'd0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 64'd0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // factor j is 2^(2^-(j+1)) in Q2.30, each one a floor root of the last
    function automatic t_fac_arr exp_factors();
        t_fac_arr f;
        logic [63:0] t;
        t = isqrt64(64'd1 << 61);
        for (int j = 0; j < 16; j++) begin
            f[j] = t[31:0];
            t = isqrt64(t << 30);
        end
        return f;
    endfunction

endpackage

// ----- hw/rtl/breakpoint_envelope_gain.sv -----
// Breakpoint envelope gain: load items fill the table, sample items are scaled.
// A load writes the table and gives no result; a linear sample multiplies and divides;
// an exponential one runs two log2 passes (normalise, squaring), a divide and exp2
// steps (none if both levels are equal); past the last segment the final level is
// used. Segment set-ups and skipped non-rising times add steps; a stalled result waits.
// Throughput: one item at a time; input stalls until the result is registered.
// Reset: synchronous, active low; clears position state, config to defaults.
module breakpoint_envelope_gain
    import beg_pkg::*;
#(
    parameter int MAX_POINTS    = 16,
    parameter int POSITION_BITS = 24,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [23:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [3:0]                    i_point_index,
    input  logic [16:0]                   i_point_time,
    input  logic [15:0]                   i_point_level,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_scaled_sample,
    output logic [15:0]                   o_gain
);
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int NW    = (AW + 1 > 5) ? AW + 1 : 5;
    localparam int P     = POSITION_BITS;
    localparam int DIV_W = 22 + P;
    localparam logic [P-1:0] POS_MAX = {P{1'b1}};
    localparam logic signed [65:0] SMAX = 66'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [65:0] SMIN = -SMAX - 66'sd1;
    localparam t_fac_arr FAC = exp_factors();

    t_state r_state, n_state;
    logic [23:0]  r_total;
    logic         r_mode;
    logic [4:0]   r_pcnt;

    t_point r_mem [MAX_POINTS];
    t_point r_rd;
    logic [AW-1:0] c_addr;

    logic [AW-1:0] r_seg, n_seg;
    logic [P-1:0]  r_left, n_left, r_k, n_k, r_step, n_step;
    logic signed [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic [16:0]   r_ta, n_ta;
    logic [15:0]   r_ya, n_ya, r_g, n_g;
    logic [31:0]   r_x, n_x, r_p, n_p;
    logic [4:0]    r_e, n_e;
    logic [15:0]   r_frac, n_frac;
    logic [3:0]    r_cnt, n_cnt, r_j, n_j;
    logic          r_lpass, n_lpass, r_neg, n_neg;
    logic [20:0]   r_l2, n_l2, r_l1, n_l1;
    logic signed [22:0] r_ev, n_ev;
    logic          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_scaled, n_scaled;
    logic [15:0]   r_gain, n_gain;

    logic               m_en;
    logic signed [32:0] m_a, m_b;
    logic signed [65:0] m_p;
    logic               d_start, d_busy, d_done;
    logic [DIV_W-1:0]   d_q;
    logic [DIV_W-1:0]   d_mag;
    logic [P-1:0]       den;

    logic in_acc;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    beg_mult u_mult (
        .i_clk (i_clk),
        .i_en  (m_en),
        .i_a   (m_a),
        .i_b   (m_b),
        .o_p   (m_p)
    );

    beg_div #(.W(DIV_W), .DW(P)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (d_start),
        .i_dividend (d_mag),
        .i_divisor  (den),
        .o_busy     (d_busy),
        .o_done     (d_done),
        .o_quotient (d_q)
    );

    always_comb begin
        logic [NW-1:0]      npts;
        logic [NW-1:0]      seg1;
        logic signed [17:0] dt;
        logic [41:0]        lsum;
        logic [25:0]        lfull;
        logic [31:0]        y1;
        logic [31:0]        ysq;
        logic signed [21:0] lr;
        logic signed [65:0] mabs;
        logic signed [16:0] qs;
        logic signed [6:0]  ne;
        logic [6:0]         sh;
        logic [63:0]        wide;
        logic signed [65:0] sq;

        n_state = r_state;
        n_seg = r_seg; n_left = r_left; n_k = r_k; n_step = r_step;
        n_sample = r_sample; n_ta = r_ta; n_ya = r_ya; n_g = r_g;
        n_x = r_x; n_p = r_p; n_e = r_e; n_frac = r_frac; n_cnt = r_cnt; n_j = r_j;
        n_lpass = r_lpass; n_neg = r_neg; n_l2 = r_l2; n_l1 = r_l1; n_ev = r_ev;
        n_out_valid = r_out_valid && i_out_stall;
        n_scaled = r_scaled; n_gain = r_gain;
        m_en = 1'b0; m_a = '0; m_b = '0;
        d_start = 1'b0;
        c_addr = r_seg;

        if (r_pcnt == 5'd0) begin
            npts = NW'(1);
        end else if (NW'(r_pcnt) > NW'(MAX_POINTS)) begin
            npts = NW'(MAX_POINTS);
        end else begin
            npts = NW'(r_pcnt);
        end
        seg1  = NW'(r_seg) + NW'(1);
        dt    = $signed({1'b0, r_rd.ptime}) - $signed({1'b0, r_ta});
        lsum  = m_p[41:0] + (r_mode ? HALF_Q16 : 42'd0);
        lfull = lsum[41:16];
        y1    = (r_ya == 16'd0) ? TINY_Q30 : {1'b0, r_ya, 15'd0};
        ysq   = m_p[61:30];
        lr    = $signed({1'b0, r_l2}) - $signed({1'b0, r_l1});
        mabs  = m_p[65] ? -m_p : m_p;
        d_mag = DIV_W'(mabs);
        den   = (r_step != '0) ? r_step : P'(1);
        qs    = r_neg ? -$signed({1'b0, d_q[15:0]}) : $signed({1'b0, d_q[15:0]});
        ne    = r_ev[22:16];
        sh    = 7'd15 - ne;
        wide  = '0;
        sq    = (m_p < 0) ? (m_p + 66'sd32767) >>> 15 : m_p >>> 15;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_sample = i_sample;
                    if (!i_action) begin
                        n_seg = '0; n_left = '0; n_k = '0; n_step = '0;
                    end else begin
                        n_state = S_SEGCHK;
                    end
                end
            end
            S_SEGCHK: begin
                if (r_left == '0 && seg1 < npts) begin
                    n_state = S_T0;
                end else if (r_left != '0 && seg1 < NW'(MAX_POINTS)) begin
                    n_state = S_L0;
                end else begin
                    c_addr  = AW'(npts - NW'(1));
                    n_state = S_FIN;
                end
            end
            S_T0: begin
                n_ta    = r_rd.ptime;
                c_addr  = AW'(seg1);
                n_state = S_T1;
            end
            S_T1: begin
                if (dt <= 18'sd0) begin
                    n_seg   = AW'(seg1);
                    n_state = S_SEGCHK;
                end else begin
                    m_en = 1'b1; m_a = 33'(dt); m_b = 33'(r_total);
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                if (lfull == '0) begin
                    n_seg = AW'(seg1);
                end else begin
                    n_left = (33'(lfull) > 33'(POS_MAX)) ? POS_MAX : P'(lfull);
                    n_step = n_left - P'(1);
                    n_k    = '0;
                end
                n_state = S_SEGCHK;
            end
            S_L0: begin
                n_ya    = r_rd.level;
                c_addr  = AW'(seg1);
                n_state = S_L1;
            end
            S_L1: begin
                if (!r_mode) begin
                    m_en = 1'b1;
                    m_a  = 33'($signed({1'b0, r_rd.level}) - $signed({1'b0, r_ya}));
                    m_b  = 33'(r_k);
                    n_state = S_LIN_M;
                end else begin
                    n_x = (r_rd.level == 16'd0) ? TINY_Q30 : {1'b0, r_rd.level, 15'd0};
                    if (n_x == y1) begin
                        n_g     = y1[30:15];
                        n_state = S_ADV;
                    end else begin
                        n_e = 5'd30; n_frac = '0; n_lpass = 1'b0;
                        n_state = S_LG_NORM;
                    end
                end
            end
            S_LIN_M: begin
                d_start = 1'b1;
                n_neg   = m_p[65];
                n_state = S_LIN_D;
            end
            S_LIN_D: begin
                if (d_done) begin
                    n_g     = 16'(17'($signed({1'b0, r_ya})) + 17'(qs));
                    n_state = S_ADV;
                end
            end
            S_LG_NORM: begin
                // shift up until the leading one sits at bit 30
                if (!r_x[30]) begin
                    n_x = {r_x[30:0], 1'b0};
                    n_e = r_e - 5'd1;
                end else begin
                    n_cnt   = '0;
                    n_state = S_LG_SQ;
                end
            end
            S_LG_SQ: begin
                m_en = 1'b1; m_a = 33'(r_x); m_b = 33'(r_x);
                n_state = S_LG_SQW;
            end
            S_LG_SQW: begin
                n_frac = {r_frac[14:0], ysq[31]};
                n_x    = ysq[31] ? {1'b0, ysq[31:1]} : ysq;
                n_cnt  = r_cnt + 4'd1;
                n_state = S_LG_SQ;
                if (r_cnt == 4'd15) begin
                    if (!r_lpass) begin
                        n_l2 = {r_e, n_frac};
                        n_x = y1; n_e = 5'd30; n_frac = '0; n_lpass = 1'b1;
                        n_state = S_LG_NORM;
                    end else begin
                        n_l1    = {r_e, n_frac};
                        n_state = S_EX_M;
                    end
                end
            end
            S_EX_M: begin
                m_en = 1'b1; m_a = 33'(lr); m_b = 33'(r_k);
                n_state = S_EX_MW;
            end
            S_EX_MW: begin
                d_start = 1'b1;
                n_neg   = m_p[65];
                n_state = S_EX_D;
            end
            S_EX_D: begin
                if (d_done) begin
                    n_ev = r_neg ? -$signed({1'b0, d_q[21:0]}) : $signed({1'b0, d_q[21:0]});
                    n_p  = ONE_Q30;
                    n_j  = '0;
                    n_state = S_EX_STEP;
                end
            end
            S_EX_STEP: begin
                if (r_ev[~r_j]) begin
                    m_en = 1'b1; m_a = 33'(r_p); m_b = 33'(FAC[r_j]);
                    n_state = S_EX_W;
                end else if (r_j == 4'd15) begin
                    n_state = S_EX_Y;
                end else begin
                    n_j = r_j + 4'd1;
                end
            end
            S_EX_W: begin
                n_p = ysq;
                n_j = r_j + 4'd1;
                n_state = (r_j == 4'd15) ? S_EX_Y : S_EX_STEP;
            end
            S_EX_Y: begin
                m_en = 1'b1; m_a = 33'(y1); m_b = 33'(r_p);
                n_state = S_EX_G;
            end
            S_EX_G: begin
                if (ne > 7'sd31) begin
                    n_g = 16'hFFFF;
                end else if (ne >= 7'sd0) begin
                    wide = (64'(ysq) << ne[4:0]) >> 15;
                    n_g  = (wide > 64'd65535) ? 16'hFFFF : wide[15:0];
                end else begin
                    wide = 64'(ysq) >> sh;
                    n_g  = wide[15:0];
                end
                n_state = S_ADV;
            end
            S_FIN: begin
                n_left  = '0;
                n_g     = r_rd.level;
                n_state = S_SMUL;
            end
            S_ADV: begin
                n_k    = r_k + P'(1);
                n_left = r_left - P'(1);
                if (r_left == P'(1)) begin
                    n_seg = AW'(seg1);
                end
                n_state = S_SMUL;
            end
            S_SMUL: begin
                m_en = 1'b1; m_a = 33'(r_sample); m_b = 33'(r_g);
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_gain      = r_g;
                    if (sq > SMAX) begin
                        n_scaled = SAMPLE_BITS'(SMAX);
                    end else if (sq < SMIN) begin
                        n_scaled = SAMPLE_BITS'(SMIN);
                    end else begin
                        n_scaled = SAMPLE_BITS'(sq);
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= 24'd48000;
            r_mode  <= 1'b0;
            r_pcnt  <= 5'd2;
            r_seg   <= '0;
            r_left  <= '0;
            r_k     <= '0;
            r_step  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seg   <= n_seg;
            r_left  <= n_left;
            r_k     <= n_k;
            r_step  <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    2'(CFG_TOTAL): r_total <= i_cfg_data;
                    2'(CFG_MODE):  r_mode  <= i_cfg_data[0];
                    2'(CFG_COUNT): r_pcnt  <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample; r_ta <= n_ta; r_ya <= n_ya; r_g <= n_g;
        r_x <= n_x; r_p <= n_p; r_e <= n_e; r_frac <= n_frac; r_cnt <= n_cnt;
        r_j <= n_j; r_lpass <= n_lpass; r_neg <= n_neg; r_l2 <= n_l2; r_l1 <= n_l1;
        r_ev <= n_ev; r_scaled <= n_scaled; r_gain <= n_gain;
    end

    // breakpoint table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_action && (NW'(i_point_index) < NW'(MAX_POINTS))) begin
            r_mem[AW'(i_point_index)] <= '{ptime: i_point_time, level: i_point_level};
        end
        r_rd <= r_mem[c_addr];
    end

    assign o_out_valid     = r_out_valid;
    assign o_scaled_sample = r_scaled;
    assign o_gain          = r_gain;

    a_ramp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != '0) |-> ((P+1)'(r_k) + (P+1)'(r_left) == (P+1)'(r_step) + (P+1)'(1)))
        else $error("ramp position and remaining count disagree");
    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_action) |=> (r_state != S_IDLE))
        else $error("sample transaction did not start the sequencer");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_done |-> $past(d_busy))
        else $error("divider finished without running");
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !d_busy)
        else $error("divider busy while idle");
endmodule

// ----- hw/rtl/beg_mult.sv -----
// Shared signed multiplier with a registered product and a load enable.
// Depends on beg_pkg.
module beg_mult
    import beg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [32:0]  i_a,
    input  logic signed [32:0]  i_b,
    output logic signed [65:0]  o_p
);
    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;
endmodule

// ----- hw/rtl/beg_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on beg_pkg.
module beg_div
    import beg_pkg::*;
#(
    parameter int W  = 46,
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [W-1:0]  i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [W-1:0]  o_quotient
);
    localparam int CW = $clog2(W + 1);

    logic [DW-1:0] r_rem;
    logic [W-1:0]  r_dvd;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic          qbit;

    always_comb begin
        trial = {r_rem, r_dvd[W-1]};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
            r_dvd <= {r_dvd[W-2:0], qbit};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_dvd;
endmodule

// ----- verif/breakpoint_envelope_gain_tb.sv -----
// Self-checking testbench for breakpoint_envelope_gain: directed table, then random phases.
// Holds its own envelope predictor; depends on beg_pkg and the block's RTL only.
`timescale 1ns / 1ps

module breakpoint_envelope_gain_tb
    import beg_pkg::*;
();

    localparam int NPTS       = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam longint POS_MAX = (64'd1 << 24) - 1;

    typedef enum logic [1:0] {ROW_LOAD, ROW_SAMPLE, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind kind;
        int        idx;
        int        tm;
        int        lvl;
        int        smp;
        bit        chk;
        int        e_scaled;
        int        e_gain;
    } t_row;

    typedef struct {
        logic signed [15:0] scaled;
        logic [15:0]        gain;
    } t_gain_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [23:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_action = 1'b0;
    logic [3:0]         i_point_index = '0;
    logic [16:0]        i_point_time = '0;
    logic [15:0]        i_point_level = '0;
    logic signed [15:0] i_sample = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [15:0] o_scaled_sample;
    logic [15:0]        o_gain;

    breakpoint_envelope_gain DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [16:0] env_time [NPTS];
    logic [15:0] env_level [NPTS];
    int          seg_idx;
    longint      seg_remain;
    longint      ramp_k;
    longint      ramp_den;
    longint      cfg_total = 48000;
    bit          cfg_expo = 1'b0;
    int          cfg_points = 2;

    t_gain_result pending_gains [$];
    int errors = 0;
    int loads_sent = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int settings_used = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    bit in_fire;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned n, res, b;
        n = v;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint log2_fix(longint unsigned v);
        int e;
        longint unsigned fr, x;
        e = 0;
        fr = 0;
        while (e < 63 && (v >> (e + 1)) != 0) e++;
        x = (e <= 30) ? (v << (30 - e)) : (v >> (e - 30));
        for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 30;
            fr = fr << 1;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                fr = fr | 1;
            end
        end
        return longint'(e) * 65536 + longint'(fr);
    endfunction

    function automatic longint unsigned pow2_fraction(longint f);
        longint unsigned p, t;
        p = 64'd1 << 30;
        t = root_floor(64'd1 << 61);
        for (int i = 15; i >= 0; i--) begin
            if (f[i]) p = (p * t) >> 30;
            t = root_floor(t << 30);
        end
        return p;
    endfunction

    function automatic longint unsigned level_fix(logic [15:0] v);
        return (v == 0) ? 64'd1074 : (longint'(v) << 15);
    endfunction

    function automatic longint curve_gain(logic [15:0] a, logic [15:0] b, longint k,
                                          longint den);
        longint unsigned y1, y2, p, g;
        longint lr, e, n, f;
        y1 = level_fix(a);
        y2 = level_fix(b);
        if (y1 == y2) return longint'(y1 >> 15);
        lr = log2_fix(y2) - log2_fix(y1);
        e = lr * k / den;
        if (e >= 0) n = e / 65536;
        else n = -((-e + 65535) / 65536);
        f = e - n * 65536;
        p = pow2_fraction(f);
        g = (y1 * p) >> 30;
        if (n >= 0) begin
            if (n > 31) return 65535;
            g = g << n;
        end else begin
            g = (n < -62) ? 0 : (g >> (-n));
        end
        g = g >> 15;
        return (g > 65535) ? 65535 : longint'(g);
    endfunction

    function automatic longint segment_span(int s);
        longint d, prod, len;
        d = longint'(env_time[s + 1]) - longint'(env_time[s]);
        if (d <= 0) return 0;
        prod = d * cfg_total;
        if (cfg_expo) prod += 32768;
        len = prod >>> 16;
        return (len > POS_MAX) ? POS_MAX : len;
    endfunction

    task automatic envelope_step(input int smp, output t_gain_result r);
        int n;
        longint len, g, prod;
        n = cfg_points;
        if (n < 1) n = 1;
        if (n > NPTS) n = NPTS;
        while (seg_remain == 0 && seg_idx + 1 < n) begin
            len = segment_span(seg_idx);
            if (len != 0) begin
                seg_remain = len;
                ramp_k = 0;
                ramp_den = len - 1;
            end else begin
                seg_idx++;
            end
        end
        if (seg_remain != 0 && seg_idx + 1 < NPTS) begin
            if (cfg_expo)
                g = curve_gain(env_level[seg_idx], env_level[seg_idx + 1], ramp_k,
                               (ramp_den != 0) ? ramp_den : 1);
            else
                g = longint'(env_level[seg_idx]) +
                    (longint'(env_level[seg_idx + 1]) - longint'(env_level[seg_idx])) *
                    ramp_k / ((ramp_den != 0) ? ramp_den : 1);
            ramp_k++;
            seg_remain--;
            if (seg_remain == 0) seg_idx++;
        end else begin
            seg_remain = 0;
            g = env_level[n - 1];
        end
        // gain never exceeds 16 bits, keep the product signed
        prod = longint'(smp) * g / 32768;
        if (prod > 32767) prod = 32767;
        if (prod < -32768) prod = -32768;
        r.scaled = prod[15:0];
        r.gain = g[15:0];
    endtask

    // drive one transaction and hold it until accepted
    task automatic push_item(input bit act, input int idx, input int tm, input int lvl,
                             input int smp, input bit chk, input int es, input int eg);
        t_gain_result r;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 20);
        end
        i_action <= act;
        i_point_index <= idx[3:0];
        i_point_time <= tm[16:0];
        i_point_level <= lvl[15:0];
        i_sample <= smp[15:0];
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        if (!act) begin
            env_time[idx] = tm[16:0];
            env_level[idx] = lvl[15:0];
            seg_idx = 0;
            seg_remain = 0;
            ramp_k = 0;
            ramp_den = 0;
            loads_sent++;
        end else begin
            envelope_step(smp, r);
            if (chk) begin
                r.scaled = es[15:0];
                r.gain = eg[15:0];
            end
            pending_gains.push_back(r);
            samples_sent++;
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_gains.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input int idx, input int val);
        drain_results();
        // a trailing load leaves no result behind; give it time to settle
        repeat (10) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx[1:0];
        i_cfg_data <= val[23:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TOTAL: cfg_total = val & 24'hFFFFFF;
            CFG_MODE:  cfg_expo = val[0];
            CFG_COUNT: cfg_points = val & 5'h1F;
            default: ;
        endcase
    endtask

    // receiver stall pattern: free, light or heavy, reshuffled now and then
    int stall_mode = 0;
    int stall_tick = 0;
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 150 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= 1'b0;
        endcase
    end

    t_gain_result want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_gains.size() == 0) begin
                $error("unexpected result: scaled_sample %0d gain %0d",
                       o_scaled_sample, o_gain);
                errors++;
            end else begin
                want = pending_gains.pop_front();
                if (o_scaled_sample !== want.scaled) begin
                    $error("scaled_sample: expected %0d, got %0d", want.scaled,
                           o_scaled_sample);
                    errors++;
                end
                if (o_gain !== want.gain) begin
                    $error("gain: expected %0d, got %0d", want.gain, o_gain);
                    errors++;
                end
            end
        end
    end

    assign in_fire = i_in_valid && !o_in_stall;

    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    t_row directed [] = '{
        '{ROW_LOAD,   0, 0,     32768, 0,      1'b0, 0,      0},
        '{ROW_LOAD,   1, 65536, 0,     0,      1'b0, 0,      0},
        '{ROW_SAMPLE, 0, 0,     0,     32767,  1'b1, 32767,  32768},
        '{ROW_SAMPLE, 0, 0,     0,     -32768, 1'b1, -32768, 32768},
        '{ROW_CFG,    CFG_TOTAL, 4, 0, 0,      1'b0, 0,      0},
        '{ROW_SAMPLE, 0, 0,     0,     16384,  1'b0, 0,      0},
        // equal levels: flat segment
        '{ROW_LOAD,   1, 65536, 32768, 0,      1'b0, 0,      0},
        '{ROW_SAMPLE, 0, 0,     0,     1000,   1'b1, 1000,   32768},
        '{ROW_SAMPLE, 0, 0,     0,     -1,     1'b1, -1,     32768},
        '{ROW_SAMPLE, 0, 0,     0,     0,      1'b0, 0,      0},
        '{ROW_SAMPLE, 0, 0,     0,     12345,  1'b0, 0,      0},
        // past the last segment the final level holds
        '{ROW_SAMPLE, 0, 0,     0,     777,    1'b1, 777,    32768},
        // time not increasing: empty segment is skipped
        '{ROW_LOAD,   0, 65536, 100,   0,      1'b0, 0,      0},
        '{ROW_SAMPLE, 0, 0,     0,     32767,  1'b1, 32767,  32768},
        '{ROW_CFG,    CFG_MODE, 1, 0,  0,      1'b0, 0,      0},
        '{ROW_LOAD,   0, 0,     0,     0,      1'b0, 0,      0},
        '{ROW_SAMPLE, 0, 0,     0,     20000,  1'b0, 0,      0},
        '{ROW_SAMPLE, 0, 0,     0,     -20000, 1'b0, 0,      0},
        '{ROW_SAMPLE, 0, 0,     0,     32767,  1'b0, 0,      0},
        // one-sample segment gives the first level
        '{ROW_CFG,    CFG_TOTAL, 1, 0, 0,      1'b0, 0,      0},
        '{ROW_LOAD,   0, 0,     8192,  0,      1'b0, 0,      0},
        '{ROW_SAMPLE, 0, 0,     0,     4,      1'b1, 1,      8192},
        '{ROW_SAMPLE, 0, 0,     0,     -32768, 1'b0, 0,      0}
    };

    int tm_acc, lvl, smp, nsamp, pick;

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG)
                write_reg(directed[i].idx, directed[i].tm);
            else
                push_item(directed[i].kind == ROW_SAMPLE, directed[i].idx, directed[i].tm,
                          directed[i].lvl, directed[i].smp, directed[i].chk,
                          directed[i].e_scaled, directed[i].e_gain);
        end

        while (loads_sent + samples_sent < 1650) begin
            pick = $urandom_range(0, 9);
            write_reg(CFG_TOTAL, (pick == 0) ? 1 : (pick == 1) ? 16777215 :
                      (pick == 2) ? $urandom_range(1, 16777215) : $urandom_range(2, 400));
            write_reg(CFG_MODE, $urandom_range(0, 1));
            pick = $urandom_range(0, 3);
            write_reg(CFG_COUNT, (pick == 0) ? 2 : (pick == 1) ? 16 : $urandom_range(2, 16));
            settings_used++;

            // fill every slot: mostly rising times, some repeats and jumps back
            tm_acc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65536) : 0;
            lvl = $urandom_range(0, 32768);
            for (int s = 0; s < NPTS; s++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) tm_acc = $urandom_range(0, 65536);
                else if (pick > 1) tm_acc = tm_acc + $urandom_range(1, 14000);
                if (tm_acc > 65536) tm_acc = 65536;
                pick = $urandom_range(0, 7);
                if (pick == 0) lvl = 0;
                else if (pick == 1) lvl = 32768;
                else if (pick > 2) lvl = $urandom_range(0, 32768);
                push_item(1'b0, s, tm_acc, lvl, $urandom_range(0, 65535), 1'b0, 0, 0);
            end

            nsamp = $urandom_range(4, 100);
            for (int j = 0; j < nsamp; j++) begin
                if ($urandom_range(0, 29) == 0) begin
                    push_item(1'b0, $urandom_range(0, 15), $urandom_range(0, 65536),
                              $urandom_range(0, 32768), $urandom_range(0, 65535), 1'b0, 0, 0);
                end else begin
                    pick = $urandom_range(0, 11);
                    smp = (pick == 0) ? -32768 : (pick == 1) ? 32767 : (pick == 2) ? -1 :
                          $urandom_range(0, 65535) - 32768;
                    push_item(1'b1, $urandom_range(0, 15), $urandom_range(0, 131071),
                              $urandom_range(0, 65535), smp, 1'b0, 0, 0);
                end
            end
        end

        drain_results();
        repeat (200) @(posedge i_clk);
        if (pending_gains.size() != 0) errors++;
        $display("Covered %0d breakpoint loads and %0d samples (%0d results checked)",
                 loads_sent, samples_sent, results_seen);
        $display("over %0d random register settings after the directed table", settings_used);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
